@@ design/ttf_pkg.sv @@
// ----------------------------------------------------------------------------
// ttf_pkg: shared definitions for the temperature transition filter
// Register indexes, verdict codes, reset values and the builder for the
// exponential lookup table.
// ----------------------------------------------------------------------------
package ttf_pkg;

	// log2 of the exponent range covered by the table (exp(-16) at the far end)
	localparam int unsigned EXP_RANGE_LOG2 = 4;
	// Taylor terms used for the per-entry step ratio
	localparam int unsigned SERIES_TERMS   = 24;
	// frontier_ratio is Q0.16 whatever the datapath fraction width
	localparam int unsigned RATIO_FRAC     = 16;
	// table entries are value/65536, entry 0 is 65536
	localparam int unsigned EXP_W          = 17;
	// near-zero cost bound is 1/NEAR_ZERO_DIV
	localparam int unsigned NEAR_ZERO_DIV  = 10000;
	// largest temp_shift code
	localparam int unsigned SHIFT_MAX      = 15;

	// configuration register indexes
	localparam logic [2:0] CFG_TEST_MODE    = 3'd0;
	localparam logic [2:0] CFG_INIT_TEMP    = 3'd1;
	localparam logic [2:0] CFG_TEMP_SHIFT   = 3'd2;
	localparam logic [2:0] CFG_GAIN         = 3'd3;
	localparam logic [2:0] CFG_FAIL_LIMIT   = 3'd4;
	localparam logic [2:0] CFG_FRONT_THRESH = 3'd5;
	localparam logic [2:0] CFG_FRONT_RATIO  = 3'd6;
	localparam logic [2:0] CFG_COST_CAP     = 3'd7;

	// register reset values
	localparam logic        RST_TEST_MODE    = 1'b0;
	localparam logic [31:0] RST_INIT_TEMP    = 32'd6554;
	localparam logic [3:0]  RST_TEMP_SHIFT   = 4'd1;
	localparam logic [31:0] RST_GAIN         = 32'd65536;
	localparam logic [7:0]  RST_FAIL_LIMIT   = 8'd10;
	localparam logic [31:0] RST_FRONT_THRESH = 32'd6554;
	localparam logic [15:0] RST_FRONT_RATIO  = 16'd6554;
	localparam logic [31:0] RST_COST_CAP     = 32'd6553600;

	typedef logic [2:0] verdict_t;

	localparam verdict_t VERDICT_RESTART  = 3'd0;
	localparam verdict_t VERDICT_GATE_REJ = 3'd1;
	localparam verdict_t VERDICT_CAP_REJ  = 3'd2;
	localparam verdict_t VERDICT_BETTER   = 3'd3;
	localparam verdict_t VERDICT_NEAR_ZERO = 3'd4;
	localparam verdict_t VERDICT_TEMP_ACC = 3'd5;
	localparam verdict_t VERDICT_TEMP_REJ = 3'd6;

	// One table entry: round(65536 * exp(-idx * step / 2^32)).
	// step is 2^(32+range)/depth; the step ratio comes from a Q0.32 series,
	// then idx truncating products walk down the curve.
	function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] step,
	                                               input int unsigned idx);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] ratio;
		logic [63:0] acc;
		int unsigned k;
		int unsigned i;
		term = 64'd1 << 32;
		pos  = term;
		neg  = 64'd0;
		for (k = 1; k <= SERIES_TERMS; k++) begin
			term = ((term * step) >> 32) / 64'(k);
			if (k[0]) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		ratio = pos - neg;
		acc   = 64'd1 << 32;
		for (i = 0; i < idx; i++) begin
			acc = (acc * ratio) >> 32;
		end
		return EXP_W'((acc + 64'h8000) >> 16);
	endfunction

endpackage

@@ design/temperature_transition_filter.sv @@
// ----------------------------------------------------------------------------
// temperature_transition_filter: transition test for a tree-based planner
// Expansion gate plus temperature-adapted acceptance test in Q16.16, run on a
// shared multiplier and a shared compare-subtract unit under a sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one candidate or a restart
//   (cmd = 1). in_stall is high while a transaction is being worked on; the
//   block takes one transaction at a time.
//   Output channel (out_valid / out_stall) returns one result per input
//   transaction from an output register. A new input is taken while that
//   result still waits; the next result waits in the sequencer until the
//   output register is free, so a stalled receiver holds the block there.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while the block is idle.
// Sequence: a restart goes straight to the result; a candidate runs the
//   gate, then the cap and cost checks, then the simple test (multiply,
//   compare) or the exponential test (multiply, divide, table index
//   steps, table lookup, compare). The divider producing dcost/distance
//   runs at one quotient bit per cycle.
// Handoff: the next transaction is taken in the cycle after the result
//   register loads.
// Reset loads the register defaults, temperature 0.1, fail count 0 and both
//   sample counters 1; no table clearing is needed.
// ----------------------------------------------------------------------------
module temperature_transition_filter
	import ttf_pkg::*;
#(
	parameter int unsigned FRAC_BITS       = 16,
	parameter int unsigned COUNT_WIDTH     = 32,
	parameter int unsigned EXP_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [31:0]        step_distance,
	input  logic signed [31:0] parent_cost,
	input  logic signed [31:0] child_cost,
	input  logic [15:0]        random_fraction,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [2:0]         verdict,
	output logic [31:0]        temperature_now,
	output logic [8:0]         fail_count_now,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// widths
	localparam int unsigned MA_W   = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam int unsigned P_W    = MA_W + 32;
	localparam int unsigned DV_W   = 32 + FRAC_BITS;
	localparam int unsigned MQ_W   = 64 - FRAC_BITS + EXP_RANGE_LOG2;
	localparam int unsigned CMP_W  = (DV_W > MQ_W) ? DV_W : MQ_W;
	localparam int unsigned CS_W   = (MQ_W + 1 > 33) ? MQ_W + 1 : 33;
	localparam int unsigned ST_W   = $clog2(DV_W);
	localparam int unsigned IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int unsigned TI_W   = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned GATE_W = COUNT_WIDTH + RATIO_FRAC;
	localparam int unsigned SH_W   = 32 + SHIFT_MAX;

	localparam logic [63:0] EXP_STEP =
		(64'd1 << (32 + EXP_RANGE_LOG2)) / 64'(EXP_TABLE_DEPTH);
	localparam logic signed [31:0] NEAR_ZERO =
		32'(((1 << FRAC_BITS) + NEAR_ZERO_DIV - 1) / NEAR_ZERO_DIV);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [IDX_W-1:0] DEPTH_VEC = IDX_W'(EXP_TABLE_DEPTH);
	localparam logic [8:0] FAIL_MAX = '1;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_GATE   = 4'd1;
	localparam logic [3:0] S_TEST   = 4'd2;
	localparam logic [3:0] S_SMUL   = 4'd3;
	localparam logic [3:0] S_SCMP   = 4'd4;
	localparam logic [3:0] S_MMUL   = 4'd5;
	localparam logic [3:0] S_DINIT  = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_QCMP   = 4'd8;
	localparam logic [3:0] S_IDXA   = 4'd9;
	localparam logic [3:0] S_IDXB   = 4'd10;
	localparam logic [3:0] S_TAB    = 4'd11;
	localparam logic [3:0] S_ECMP   = 4'd12;
	localparam logic [3:0] S_FINISH = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	// control state
	logic [3:0]             state_q;
	logic [ST_W-1:0]        step_q;
	logic [IDX_W-1:0]       dbits_q;
	logic                   pass_q;
	verdict_t               verdict_q;
	logic                   out_valid_q;

	// configuration registers
	logic                   mode_q;
	logic [31:0]            init_temp_q;
	logic [3:0]             shift_q;
	logic [31:0]            gain_q;
	logic [7:0]             fail_limit_q;
	logic [31:0]            thresh_q;
	logic [15:0]            ratio_q;
	logic signed [31:0]     cap_q;

	// filter state
	logic [31:0]            temperature_q;
	logic [8:0]             fail_q;
	logic [COUNT_WIDTH-1:0] frontier_q;
	logic [COUNT_WIDTH-1:0] refine_q;

	// datapath registers
	logic [31:0]            dist_q;
	logic signed [31:0]     parent_q;
	logic signed [31:0]     child_q;
	logic [15:0]            rnd_q;
	logic [31:0]            dcost_q;
	logic [P_W-1:0]         prod_q;
	logic [MQ_W-1:0]        m_q;
	logic [DV_W-1:0]        quo_q;
	logic [CS_W-1:0]        rem_q;
	logic [MQ_W-1:0]        qop_q;
	logic [IDX_W-1:0]       qi_q;
	logic [EXP_W-1:0]       tab_q;
	logic                   out_acc_q;
	verdict_t               out_verdict_q;
	logic [31:0]            out_temp_q;
	logic [8:0]             out_fail_q;

	// combinational
	logic                   mul_en;
	logic [MA_W-1:0]        mul_a;
	logic [31:0]            mul_b;
	logic [CS_W-1:0]        cs_a;
	logic [CS_W-1:0]        cs_b;
	logic [CS_W-1:0]        cs_diff;
	logic                   cs_ge;
	logic [CS_W-1:0]        cs_res;
	logic                   is_frontier;
	logic                   gate_reject;
	logic                   out_free;
	logic [31:0]            temp_down;
	logic [SH_W-1:0]        temp_up_w;
	logic [31:0]            temp_up;
	logic [31:0]            restart_temp;
	logic [EXP_W-1:0]       exp_tab [EXP_TABLE_DEPTH];

	// exponential table, constant logic
	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_exp_tab
		assign exp_tab[gi] = exp_entry(EXP_STEP, gi);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign accepted        = out_acc_q;
	assign verdict         = out_verdict_q;
	assign temperature_now = out_temp_q;
	assign fail_count_now  = out_fail_q;

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = MA_W'(temperature_q);
		mul_b  = dist_q;
		unique case (state_q)
			S_GATE: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(frontier_q);
				mul_b  = 32'(ratio_q);
			end
			S_SMUL: begin
				mul_en = 1'b1;
			end
			S_MMUL: begin
				mul_en = 1'b1;
				mul_b  = gain_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// shared compare-subtract unit: divider steps and table index steps
	always_comb begin
		unique case (state_q)
			S_IDXA: begin
				cs_a = CS_W'({rem_q[MQ_W-1:0], 1'b0});
				cs_b = CS_W'(m_q);
			end
			S_IDXB: begin
				cs_a = CS_W'(rem_q[MQ_W-1:0]) + CS_W'(qop_q);
				cs_b = CS_W'(m_q);
			end
			default: begin
				cs_a = CS_W'({rem_q[31:0], quo_q[DV_W-1]});
				cs_b = CS_W'(dist_q);
			end
		endcase
		cs_diff = cs_a - cs_b;
		cs_ge   = (cs_a >= cs_b);
		cs_res  = cs_ge ? cs_diff : cs_a;
	end

	// expansion gate and temperature moves
	always_comb begin
		is_frontier  = (dist_q > thresh_q);
		gate_reject  = !is_frontier &&
		               ({refine_q, {RATIO_FRAC{1'b0}}} > prod_q[GATE_W-1:0]);
		temp_down    = temperature_q >> shift_q;
		if (temp_down == '0) begin
			temp_down = 32'd1;
		end
		temp_up_w    = SH_W'(temperature_q) << shift_q;
		temp_up      = (temp_up_w[SH_W-1:32] != '0) ? '1 : temp_up_w[31:0];
		restart_temp = (init_temp_q == '0) ? 32'd1 : init_temp_q;
	end

	// sequencer, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			dbits_q       <= '0;
			pass_q        <= 1'b0;
			verdict_q     <= VERDICT_RESTART;
			out_valid_q   <= 1'b0;
			mode_q        <= RST_TEST_MODE;
			init_temp_q   <= RST_INIT_TEMP;
			shift_q       <= RST_TEMP_SHIFT;
			gain_q        <= RST_GAIN;
			fail_limit_q  <= RST_FAIL_LIMIT;
			thresh_q      <= RST_FRONT_THRESH;
			ratio_q       <= RST_FRONT_RATIO;
			cap_q         <= RST_COST_CAP;
			temperature_q <= RST_INIT_TEMP;
			fail_q        <= '0;
			frontier_q    <= COUNT_WIDTH'(1);
			refine_q      <= COUNT_WIDTH'(1);
		end else begin
			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TEST_MODE:    mode_q       <= cfg_data[0];
					CFG_INIT_TEMP:    init_temp_q  <= cfg_data;
					CFG_TEMP_SHIFT:   shift_q      <= cfg_data[3:0];
					CFG_GAIN:         gain_q       <= cfg_data;
					CFG_FAIL_LIMIT:   fail_limit_q <= cfg_data[7:0];
					CFG_FRONT_THRESH: thresh_q     <= cfg_data;
					CFG_FRONT_RATIO:  ratio_q      <= cfg_data[15:0];
					CFG_COST_CAP:     cap_q        <= cfg_data;
				endcase
			end

			// output register handshake
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd) begin
							temperature_q <= restart_temp;
							fail_q        <= '0;
							frontier_q    <= COUNT_WIDTH'(1);
							refine_q      <= COUNT_WIDTH'(1);
							verdict_q     <= VERDICT_RESTART;
							state_q       <= S_DONE;
						end else begin
							state_q <= S_GATE;
						end
					end
				end
				S_GATE: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (gate_reject) begin
						verdict_q <= VERDICT_GATE_REJ;
						state_q   <= S_DONE;
					end else begin
						if (is_frontier) begin
							if (frontier_q != COUNT_MAX) begin
								frontier_q <= frontier_q + COUNT_WIDTH'(1);
							end
						end else if (refine_q != COUNT_MAX) begin
							refine_q <= refine_q + COUNT_WIDTH'(1);
						end
						priority if (mode_q && child_q >= cap_q) begin
							verdict_q <= VERDICT_CAP_REJ;
							state_q   <= S_DONE;
						end else if (child_q < parent_q) begin
							verdict_q <= VERDICT_BETTER;
							state_q   <= S_DONE;
						end else if (child_q < NEAR_ZERO) begin
							verdict_q <= VERDICT_NEAR_ZERO;
							state_q   <= S_DONE;
						end else if (dist_q == '0) begin
							pass_q  <= 1'b0;
							state_q <= S_FINISH;
						end else if (mode_q) begin
							state_q <= S_SMUL;
						end else begin
							state_q <= S_MMUL;
						end
					end
				end
				S_SMUL: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					pass_q  <= (prod_q > P_W'({dcost_q, {FRAC_BITS{1'b0}}}));
					state_q <= S_FINISH;
				end
				S_MMUL: begin
					state_q <= S_DINIT;
				end
				S_DINIT: begin
					step_q  <= ST_W'(DV_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_QCMP;
					end else begin
						step_q <= step_q - ST_W'(1);
					end
				end
				S_QCMP: begin
					priority if (quo_q == '0) begin
						state_q <= S_TAB;
					end else if (CMP_W'(quo_q) >= CMP_W'(m_q)) begin
						pass_q  <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						step_q  <= ST_W'(IDX_W - 1);
						dbits_q <= DEPTH_VEC;
						state_q <= S_IDXA;
					end
				end
				S_IDXA: begin
					priority if (dbits_q[IDX_W-1]) begin
						state_q <= S_IDXB;
					end else if (step_q == '0) begin
						state_q <= S_TAB;
					end else begin
						step_q  <= step_q - ST_W'(1);
						dbits_q <= dbits_q << 1;
					end
				end
				S_IDXB: begin
					if (step_q == '0) begin
						state_q <= S_TAB;
					end else begin
						step_q  <= step_q - ST_W'(1);
						dbits_q <= dbits_q << 1;
						state_q <= S_IDXA;
					end
				end
				S_TAB: begin
					state_q <= S_ECMP;
				end
				S_ECMP: begin
					pass_q  <= (tab_q > EXP_W'(rnd_q));
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (pass_q) begin
						temperature_q <= temp_down;
						fail_q        <= '0;
						verdict_q     <= VERDICT_TEMP_ACC;
					end else begin
						if (fail_q > 9'(fail_limit_q)) begin
							temperature_q <= temp_up;
							fail_q        <= '0;
						end else if (fail_q != FAIL_MAX) begin
							fail_q <= fail_q + 9'd1;
						end
						verdict_q <= VERDICT_TEMP_REJ;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			dist_q   <= step_distance;
			parent_q <= parent_cost;
			child_q  <= child_cost;
			rnd_q    <= random_fraction;
		end
		if (mul_en) begin
			prod_q <= P_W'(mul_a) * P_W'(mul_b);
		end
		unique case (state_q)
			S_TEST: begin
				dcost_q <= 32'(child_q - parent_q);
			end
			S_DINIT: begin
				m_q   <= {prod_q[63:FRAC_BITS], {EXP_RANGE_LOG2{1'b0}}};
				quo_q <= {dcost_q, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			S_DIV: begin
				quo_q <= {quo_q[DV_W-2:0], cs_ge};
				rem_q <= cs_res;
			end
			S_QCMP: begin
				rem_q <= '0;
				qi_q  <= '0;
				qop_q <= MQ_W'(quo_q);
			end
			S_IDXA: begin
				qi_q  <= {qi_q[IDX_W-2:0], cs_ge};
				rem_q <= cs_res;
			end
			S_IDXB: begin
				qi_q  <= qi_q + IDX_W'(cs_ge);
				rem_q <= cs_res;
			end
			S_TAB: begin
				tab_q <= exp_tab[TI_W'(qi_q)];
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_acc_q     <= (verdict_q == VERDICT_BETTER) ||
			                 (verdict_q == VERDICT_NEAR_ZERO) ||
			                 (verdict_q == VERDICT_TEMP_ACC);
			out_verdict_q <= verdict_q;
			out_temp_q    <= temperature_q;
			out_fail_q    <= fail_q;
		end
	end

	// checks
	a_temp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		temperature_q != '0)
		else $error("temperature reached zero");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < CS_W'(dist_q))
		else $error("divider remainder not below distance");

	a_idx_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDXA || state_q == S_IDXB) |-> rem_q < CS_W'(m_q))
		else $error("index remainder not below exponent span");

	a_tab_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAB |-> qi_q < DEPTH_VEC)
		else $error("table index out of range");

	a_acc_clears_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_TEMP_ACC |-> fail_count_now == '0)
		else $error("temperature accept left a failure count");

endmodule
